// ===== hw/rtl/lbc_pkg.sv =====
`default_nettype none
package lbc_pkg;
	localparam int SLOTS = 32;
	localparam int SW = 5;
	localparam int LW = 6;
	localparam logic [LW-1:0] NIL = 6'd63;
	localparam logic [5:0] MIN_IN_USE = 6'd4;
	localparam logic [5:0] MAX_IN_USE = 6'd32;

	typedef enum logic [1:0] {
		OP_LOCK = 2'd0,
		OP_UNLOCK = 2'd1,
		OP_FLUSH = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_FREE = 3'd1;
	localparam logic [2:0] ST_PINNED = 3'd2;
	localparam logic [2:0] ST_NOT_CACHED = 3'd3;
	localparam logic [2:0] ST_NOT_PINNED = 3'd4;
	localparam logic [2:0] ST_FILL_FAIL = 3'd5;
	localparam logic [2:0] ST_WR_ERR = 3'd6;

	typedef struct packed {
		logic [1:0] opcode;
		logic [31:0] block;
		logic for_write;
		logic fill_ok;
		logic writeback_ok;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] slot;
		logic writeback_valid;
		logic [4:0] writeback_slot;
		logic [31:0] writeback_block;
		logic fill_valid;
		logic [4:0] fill_slot;
		logic [31:0] fill_block;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic last;
	} out_word_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lbc_ram.sv =====
`default_nettype none
module lbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lru_block_cache_with_pinning_core.sv =====
`default_nettype none
// Write-back block cache tag manager with LRU replacement and pinning.
// Command channel: in_word is taken when start is high and busy is low.
// Results leave on out_word, one cycle each, marked by done; the word
// with last set ends the item. The receiver cannot stall.
// Configuration: cfg_we writes cfg_data (slots in use, 4..32) and empties
// the cache; write it only while idle.
// Tags sit in a one-read-port RAM; valid, dirty, pinned and the list links
// are flip-flops. Lock and unlock scan the slots in use one per cycle
// through the tag RAM, then read the tail tag for a possible write-back.
// On a miss the result word follows the scan and the tail tag read
// (sooner on an early hit); busy drops with it, and no new command is
// taken before that. A flush walks the list from the head with one
// write-back word per dirty slot, then gives its status word. Clear
// answers in the next cycle and does not raise busy.
// Reset and clear: all slots invalid, list in slot order, counters zero.
module lru_block_cache_with_pinning_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire lbc_pkg::in_word_t in_word,
	output logic done,
	output lbc_pkg::out_word_t out_word,
	input wire logic cfg_we,
	input wire logic [5:0] cfg_data
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FLUSH, S_FLUSH_END} state_t;
	state_t state_q;
	lbc_pkg::in_word_t cmd_q;
	logic [lbc_pkg::SLOTS-1:0] valid_q, dirty_q, pinned_q;
	logic [lbc_pkg::LW-1:0] newer_q [lbc_pkg::SLOTS];
	logic [lbc_pkg::LW-1:0] older_q [lbc_pkg::SLOTS];
	logic [lbc_pkg::LW-1:0] head_q, tail_q, inuse_q;
	logic [31:0] hits_q, misses_q;
	logic sticky_q;
	logic [lbc_pkg::LW-1:0] idx_q, fidx_q;
	logic rd_pend_q, flush_rd_q;
	logic [lbc_pkg::SW-1:0] rslot_q;
	logic found_q;
	logic [lbc_pkg::SW-1:0] fslot_q;

	logic tag_we;
	logic [lbc_pkg::SW-1:0] tag_waddr, tag_raddr;
	logic [31:0] tag_wdata, tag_rdata;

	lbc_ram #(.WIDTH(32), .DEPTH(lbc_pkg::SLOTS)) u_tag (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(tag_raddr), .rdata(tag_rdata)
	);

	assign busy = (state_q != S_IDLE);

	logic [5:0] cfg_sat;
	always_comb begin
		cfg_sat = cfg_data;
		if (cfg_sat > lbc_pkg::MAX_IN_USE) cfg_sat = lbc_pkg::MAX_IN_USE;
	end

	// read address: scanning slot index, then the tail slot once the scan
	// has passed the last slot, or the flush walker slot
	always_comb begin
		tag_raddr = (state_q == S_FLUSH) ? fidx_q[lbc_pkg::SW-1:0]
			: (idx_q < inuse_q) ? idx_q[lbc_pkg::SW-1:0]
			: tail_q[lbc_pkg::SW-1:0];
		tag_we = 1'b0;
		tag_waddr = tail_q[lbc_pkg::SW-1:0];
		tag_wdata = cmd_q.block;
		if (state_q == S_SCAN && !rd_pend_q && !found_q && idx_q == inuse_q
			&& cmd_q.opcode == lbc_pkg::OP_LOCK && tail_q != lbc_pkg::NIL)
			tag_we = 1'b1;
	end

	// match on the word read last cycle
	logic hit_now;
	assign hit_now = rd_pend_q && valid_q[rslot_q] && tag_rdata == cmd_q.block;

	always_ff @(posedge clk or negedge arst_n) begin
		logic [lbc_pkg::LW-1:0] n, o, s, nin;
		logic [lbc_pkg::SW-1:0] ss;
		lbc_pkg::out_word_t w;
		logic dn;
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			dirty_q <= '0;
			pinned_q <= '0;
			for (int i = 0; i < lbc_pkg::SLOTS; i++) begin
				newer_q[i] <= (i == 0) ? lbc_pkg::NIL : lbc_pkg::LW'(i - 1);
				older_q[i] <= (i == lbc_pkg::SLOTS - 1) ? lbc_pkg::NIL
					: lbc_pkg::LW'(i + 1);
			end
			head_q <= '0;
			tail_q <= lbc_pkg::LW'(lbc_pkg::SLOTS - 1);
			inuse_q <= lbc_pkg::LW'(lbc_pkg::SLOTS);
			hits_q <= '0;
			misses_q <= '0;
			sticky_q <= 1'b0;
			idx_q <= '0;
			fidx_q <= '0;
			rd_pend_q <= 1'b0;
			flush_rd_q <= 1'b0;
			rslot_q <= '0;
			found_q <= 1'b0;
			fslot_q <= '0;
			done <= 1'b0;
			out_word <= '0;
			cmd_q <= '0;
		end else begin
			dn = 1'b0;
			w = '0;
			w.last = 1'b1;
			nin = inuse_q;
			if (cfg_we && cfg_data >= lbc_pkg::MIN_IN_USE) nin = cfg_sat;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we && cfg_data >= lbc_pkg::MIN_IN_USE) begin
						inuse_q <= nin;
					end
					if ((cfg_we && cfg_data >= lbc_pkg::MIN_IN_USE)
						|| (start && in_word.opcode == lbc_pkg::OP_CLEAR)) begin
						// empty the cache and rebuild the chain
						valid_q <= '0;
						dirty_q <= '0;
						pinned_q <= '0;
						for (int i = 0; i < lbc_pkg::SLOTS; i++) begin
							if (lbc_pkg::LW'(i) < nin) begin
								newer_q[i] <= (i == 0) ? lbc_pkg::NIL
									: lbc_pkg::LW'(i - 1);
								older_q[i] <= (lbc_pkg::LW'(i + 1) == nin)
									? lbc_pkg::NIL : lbc_pkg::LW'(i + 1);
							end else begin
								newer_q[i] <= lbc_pkg::NIL;
								older_q[i] <= lbc_pkg::NIL;
							end
						end
						head_q <= '0;
						tail_q <= nin - 6'd1;
						hits_q <= '0;
						misses_q <= '0;
						sticky_q <= 1'b0;
					end
					if (start) begin
						cmd_q <= in_word;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						found_q <= 1'b0;
						fidx_q <= head_q;
						flush_rd_q <= 1'b0;
						fslot_q <= '0;
						unique case (in_word.opcode)
							lbc_pkg::OP_LOCK, lbc_pkg::OP_UNLOCK: state_q <= S_SCAN;
							lbc_pkg::OP_FLUSH: state_q <= S_FLUSH;
							default: begin
								w.hit_count = '0;
								w.miss_count = '0;
								out_word <= w;
								dn = 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit_now && !found_q) begin
						found_q <= 1'b1;
						fslot_q <= rslot_q;
					end
					if (idx_q < inuse_q && !(hit_now || found_q)) begin
						rd_pend_q <= 1'b1;
						rslot_q <= idx_q[lbc_pkg::SW-1:0];
						idx_q <= idx_q + 6'd1;
					end else if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						// scan finished: act on the result
						ss = fslot_q;
						state_q <= S_IDLE;
						dn = 1'b1;
						w.hit_count = hits_q;
						w.miss_count = misses_q;
						if (cmd_q.opcode == lbc_pkg::OP_UNLOCK) begin
							if (!found_q) w.status = lbc_pkg::ST_NOT_CACHED;
							else if (!pinned_q[ss]) w.status = lbc_pkg::ST_NOT_PINNED;
							else begin
								pinned_q[ss] <= 1'b0;
								newer_q[ss] <= lbc_pkg::NIL;
								older_q[ss] <= head_q;
								if (head_q != lbc_pkg::NIL)
									newer_q[head_q[lbc_pkg::SW-1:0]] <= {1'b0, ss};
								else tail_q <= {1'b0, ss};
								head_q <= {1'b0, ss};
								w.slot = ss;
							end
						end else if (found_q) begin
							if (pinned_q[ss]) w.status = lbc_pkg::ST_PINNED;
							else begin
								w.hit_count = hits_q + 32'd1;
								hits_q <= hits_q + 32'd1;
								n = newer_q[ss];
								o = older_q[ss];
								if (n != lbc_pkg::NIL) older_q[n[lbc_pkg::SW-1:0]] <= o;
								else head_q <= o;
								if (o != lbc_pkg::NIL) newer_q[o[lbc_pkg::SW-1:0]] <= n;
								else tail_q <= n;
								newer_q[ss] <= lbc_pkg::NIL;
								older_q[ss] <= lbc_pkg::NIL;
								pinned_q[ss] <= 1'b1;
								if (cmd_q.for_write) dirty_q[ss] <= 1'b1;
								w.slot = ss;
							end
						end else begin
							w.miss_count = misses_q + 32'd1;
							misses_q <= misses_q + 32'd1;
							s = tail_q;
							if (s == lbc_pkg::NIL) w.status = lbc_pkg::ST_NO_FREE;
							else begin
								ss = s[lbc_pkg::SW-1:0];
								n = newer_q[ss];
								if (valid_q[ss] && dirty_q[ss]) begin
									// tail tag was read right after the scan
									w.writeback_valid = 1'b1;
									w.writeback_slot = ss;
									w.writeback_block = tag_rdata;
									if (!cmd_q.writeback_ok) sticky_q <= 1'b1;
								end
								w.fill_valid = 1'b1;
								w.fill_slot = ss;
								w.fill_block = cmd_q.block;
								dirty_q[ss] <= cmd_q.for_write & cmd_q.fill_ok;
								if (!cmd_q.fill_ok) begin
									// stays at the tail; list unchanged
									valid_q[ss] <= 1'b0;
									pinned_q[ss] <= 1'b0;
									w.status = lbc_pkg::ST_FILL_FAIL;
								end else begin
									valid_q[ss] <= 1'b1;
									pinned_q[ss] <= 1'b1;
									if (n != lbc_pkg::NIL) older_q[n[lbc_pkg::SW-1:0]] <= lbc_pkg::NIL;
									else head_q <= lbc_pkg::NIL;
									tail_q <= n;
									newer_q[ss] <= lbc_pkg::NIL;
									older_q[ss] <= lbc_pkg::NIL;
									w.slot = ss;
								end
							end
						end
						out_word <= w;
					end
				end
				S_FLUSH: begin
					// walker: fidx_q addresses the RAM, fslot_q holds last read slot
					if (flush_rd_q) begin
						flush_rd_q <= 1'b0;
						if (dirty_q[fslot_q]) begin
							dirty_q[fslot_q] <= 1'b0;
							if (!cmd_q.writeback_ok) sticky_q <= 1'b1;
							w.last = 1'b0;
							w.writeback_valid = 1'b1;
							w.writeback_slot = fslot_q;
							w.writeback_block = tag_rdata;
							w.hit_count = hits_q;
							w.miss_count = misses_q;
							out_word <= w;
							dn = 1'b1;
						end
					end else if (fidx_q != lbc_pkg::NIL && idx_q < inuse_q) begin
						flush_rd_q <= 1'b1;
						fslot_q <= fidx_q[lbc_pkg::SW-1:0];
						fidx_q <= older_q[fidx_q[lbc_pkg::SW-1:0]];
						idx_q <= idx_q + 6'd1;
					end else begin
						state_q <= S_FLUSH_END;
					end
				end
				S_FLUSH_END: begin
					w.status = sticky_q ? lbc_pkg::ST_WR_ERR : lbc_pkg::ST_OK;
					w.hit_count = hits_q;
					w.miss_count = misses_q;
					sticky_q <= 1'b0;
					out_word <= w;
					dn = 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			done <= dn;
		end
	end
endmodule
`default_nettype wire
